FILE: rtl/pfu_pkg.sv
// Package for the processor status word flag update unit.
// Holds the op codes, the item and status word types and the flag bit places.
// No dependencies.
`default_nettype none

package pfu_pkg;

    typedef enum logic [3:0] {
        OP_ADD8    = 4'd0,
        OP_SUB8    = 4'd1,
        OP_LOGIC8  = 4'd2,
        OP_SHIFT8  = 4'd3,
        OP_SHIFT16 = 4'd4,
        OP_MULDIV8 = 4'd5,
        OP_ADD16   = 4'd6,
        OP_SUB16   = 4'd7,
        OP_LOGIC16 = 4'd8,
        OP_PARITY  = 4'd9,
        OP_LOAD    = 4'd10
    } op_t;

    // Flag bit places in word one.
    localparam int unsigned BIT_CY = 7;
    localparam int unsigned BIT_AC = 6;
    localparam int unsigned BIT_OV = 2;
    localparam int unsigned BIT_P  = 0;
    // Flag bit places in word two.
    localparam int unsigned BIT_N  = 5;
    localparam int unsigned BIT_Z  = 1;

    // Odd parity of a nibble, indexed by the nibble.
    localparam logic [15:0] PARITY_TABLE = 16'h6996;

    typedef struct packed {
        op_t         op;
        logic [16:0] raw_result;
        logic [15:0] operand_a;
        logic [15:0] operand_b;
        logic        carry_in;
        logic        update_parity;
        logic        shift_carry;
        logic        overflow_in;
    } item_t;

    typedef struct packed {
        logic [7:0] two;
        logic [7:0] one;
    } psw_t;

    function automatic logic odd_parity8(input logic [7:0] v);
        logic [3:0] x;
        x = v[7:4] ^ v[3:0];
        return PARITY_TABLE[x];
    endfunction

endpackage

`default_nettype wire

FILE: rtl/pfu_in_reg.sv
// Input register stage of the flag update unit.
// Holds one accepted item until the flag stage takes it; uses pfu_pkg.
`default_nettype none

module pfu_in_reg
    import pfu_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  in_valid,
    output logic       in_ready,
    input  wire item_t in_item,
    input  wire logic  advance,
    output logic       item_valid,
    output item_t      item
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    // The stage can take a new item when empty or when its item leaves now.
    assign in_ready = !valid_reg || advance;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_valid && in_ready)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

`default_nettype wire

FILE: rtl/pfu_flag_calc.sv
// Combinational flag rules of the flag update unit.
// Computes both new status words from the current words and one item; uses pfu_pkg.
`default_nettype none

module pfu_flag_calc
    import pfu_pkg::*;
(
    input  wire item_t item,
    input  wire psw_t  cur,
    output psw_t       nxt
);

    logic [16:0] r;
    logic [15:0] a;
    logic [15:0] b;
    logic [4:0]  nib_sum;
    logic [4:0]  nib_sub;
    logic        ac_add;
    logic        ac_sub;
    logic        ov_add8;
    logic        ov_sub8;
    logic        ov_add16;
    logic        ov_sub16;
    logic        z8;
    logic        z16;
    logic        par;

    assign r = item.raw_result;
    assign a = item.operand_a;
    assign b = item.operand_b;

    assign nib_sum = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'b0, item.carry_in};
    assign nib_sub = {1'b0, b[3:0]} + {4'b0, item.carry_in};
    assign ac_add  = nib_sum[4];
    assign ac_sub  = ({1'b0, a[3:0]} < nib_sub);

    assign ov_add8  = ~(a[7] ^ b[7]) & (a[7] ^ r[7]);
    assign ov_sub8  =  (a[7] ^ b[7]) & (a[7] ^ r[7]);
    assign ov_add16 = ~(a[15] ^ b[15]) & (a[15] ^ r[15]);
    assign ov_sub16 =  (a[15] ^ b[15]) & (a[15] ^ r[15]);

    assign z8  = (r[7:0] == 8'h00);
    assign z16 = (r[15:0] == 16'h0000);
    assign par = odd_parity8(r[7:0]);

    always_comb
    begin
        nxt = cur;
        unique case (item.op)
            OP_ADD8, OP_SUB8:
            begin
                nxt.one[BIT_CY] = r[8];
                nxt.one[BIT_AC] = (item.op == OP_ADD8) ? ac_add : ac_sub;
                nxt.one[BIT_OV] = (item.op == OP_ADD8) ? ov_add8 : ov_sub8;
                nxt.two[BIT_N]  = r[7];
                nxt.two[BIT_Z]  = z8;
                if (item.update_parity)
                begin
                    nxt.one[BIT_P] = par;
                end
            end
            OP_LOGIC8:
            begin
                nxt.two[BIT_N] = r[7];
                nxt.two[BIT_Z] = z8;
            end
            OP_SHIFT8:
            begin
                nxt.one[BIT_CY] = item.shift_carry;
                nxt.two[BIT_N]  = r[7];
                nxt.two[BIT_Z]  = z8;
            end
            OP_SHIFT16:
            begin
                nxt.one[BIT_CY] = item.shift_carry;
                nxt.two[BIT_N]  = r[15];
                nxt.two[BIT_Z]  = z16;
            end
            OP_MULDIV8:
            begin
                nxt.one[BIT_CY] = 1'b0;
                nxt.one[BIT_OV] = item.overflow_in;
            end
            OP_ADD16, OP_SUB16:
            begin
                nxt.one[BIT_CY] = r[16];
                nxt.one[BIT_OV] = (item.op == OP_ADD16) ? ov_add16 : ov_sub16;
                nxt.two[BIT_N]  = r[15];
                nxt.two[BIT_Z]  = z16;
            end
            OP_LOGIC16:
            begin
                nxt.two[BIT_N] = r[15];
                nxt.two[BIT_Z] = z16;
            end
            OP_PARITY:
            begin
                nxt.one[BIT_P] = par;
            end
            OP_LOAD:
            begin
                nxt.one = a[7:0];
                nxt.two = b[7:0];
            end
            default:
            begin
                // Codes without a rule leave both words as they are.
                nxt = cur;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/psw_flag_update_unit.sv
// Top level of the processor status word flag update unit.
// Instantiates pfu_in_reg and pfu_flag_calc and holds the status words; uses pfu_pkg.
//
// Usage:
// The slave channel (s_axis_*) takes one item per ALU operation: the op code on
// tuser and the raw result, both operands and the carry, parity, shift and
// overflow inputs on tdata. The master channel (m_axis_*) returns one item for
// every input item, holding both status words after that operation's update.
//
// An accepted item first sits in the input register; then the flag rules are
// evaluated and written into the status word registers, which are also the
// result register.
// Throughput is one item per clock while the receiver takes every result; the
// input register and the status word registers form a two-entry pipeline, so a
// new item is taken while a finished result is still waiting to be taken.
//
// When the receiver stalls, the result holds and the input register fills;
// s_axis_tready then drops until the result is taken. Each item updates the
// words left by the one before; they change only as an item enters the result slot.
//
// Reset clears both status words to zero and empties the pipeline.
`default_nettype none

module psw_flag_update_unit
    import pfu_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // [16:0] raw_result, [32:17] operand_a, [48:33] operand_b, [49] carry_in,
    // [50] update_parity, [51] shift_carry, [52] overflow_in, [55:53] zero
    input  wire logic [55:0] s_axis_tdata,
    // [3:0] op
    input  wire logic [3:0]  s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [7:0] status_word, [15:8] status_word_two
    output logic [15:0]      m_axis_tdata
);

    item_t in_item;
    item_t item;
    logic  item_valid;
    logic  advance;
    psw_t  psw_reg;
    psw_t  psw_next;
    logic  out_valid_reg;
    logic  out_valid_next;

    // Unpack the stream item into its fields; the pad bits are ignored.
    assign in_item.op            = op_t'(s_axis_tuser);
    assign in_item.raw_result    = s_axis_tdata[16:0];
    assign in_item.operand_a     = s_axis_tdata[32:17];
    assign in_item.operand_b     = s_axis_tdata[48:33];
    assign in_item.carry_in      = s_axis_tdata[49];
    assign in_item.update_parity = s_axis_tdata[50];
    assign in_item.shift_carry   = s_axis_tdata[51];
    assign in_item.overflow_in   = s_axis_tdata[52];

    // The held item moves on when the result slot is empty or being emptied.
    assign advance = item_valid && (!out_valid_reg || m_axis_tready);

    pfu_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_item    (in_item),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    pfu_flag_calc u_flag_calc (
        .item (item),
        .cur  (psw_reg),
        .nxt  (psw_next)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // The status words are architectural state, so they are reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            psw_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                psw_reg <= psw_next;
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {psw_reg.two, psw_reg.one};

endmodule

`default_nettype wire

FILE: rtl/pfu_checker.sv
// Port-level checker for the flag update unit, bound to its top level.
// Uses pfu_pkg for the op codes; watches only the top level's ports.
`default_nettype none

module pfu_checker
    import pfu_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic [55:0] s_axis_tdata,
    input wire logic [3:0]  s_axis_tuser,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [15:0] m_axis_tdata
);

    logic       s_acc;
    logic       m_acc;
    logic [1:0] inflight_reg;
    logic [1:0] inflight_next;

    assign s_acc = s_axis_tvalid && s_axis_tready;
    assign m_acc = m_axis_tvalid && m_axis_tready;

    always_comb
    begin
        inflight_next = inflight_reg + {1'b0, s_acc} - {1'b0, m_acc};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inflight_reg <= 2'd0;
        end
        else
        begin
            inflight_reg <= inflight_next;
        end
    end

    // A stalled result stays put.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // The block holds at most two items and shows a result only for one taken.
    a_inflight: assert property (@(posedge clk) disable iff (!rst_n)
        (inflight_reg != 2'd3) && (!m_axis_tvalid || inflight_reg != 2'd0))
        else $error("item count out of range");

    // Back-pressure only while a result is waiting.
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input stalled with no result pending");

    // A load with a free output path shows its words from the status word registers.
    a_load: assert property (@(posedge clk) disable iff (!rst_n)
        (s_acc && s_axis_tuser == OP_LOAD) ##1 m_axis_tready |=>
            m_axis_tvalid
            && m_axis_tdata[7:0] == $past(s_axis_tdata[24:17], 2)
            && m_axis_tdata[15:8] == $past(s_axis_tdata[40:33], 2))
        else $error("load result wrong");

endmodule

bind psw_flag_update_unit pfu_checker u_pfu_checker (.*);

`default_nettype wire

FILE: tb/sv/psw_flag_update_unit_tb.sv
// Testbench for psw_flag_update_unit: drives ALU flag-update items, checks the status words.
// It predicts both words itself and compares every returned item against that prediction.
// Depends on pfu_pkg and psw_flag_update_unit from the RTL.
`default_nettype none

module psw_flag_update_unit_tb
    import pfu_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    // Op codes that the unit does not decode; they must leave both words alone.
    localparam logic [3:0] OP_FIRST_UNUSED = 4'd11;
    localparam logic [3:0] OP_LAST_UNUSED  = 4'd15;

    localparam int RANDOM_ITEMS  = 2000;
    localparam int QUIET_TAIL    = 150;   // items at the end sent with no idling at all
    localparam int HOLD_AT       = 400;   // the long receiver hold-off starts around here
    localparam int HOLD_CYCLES   = 60;
    localparam int STALL_LIMIT   = 1000;  // cycles with no item moving on either side
    localparam int DRAIN_CYCLES  = 8;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // [16:0] raw_result, [32:17] operand_a, [48:33] operand_b, [49] carry_in,
    // [50] update_parity, [51] shift_carry, [52] overflow_in, [55:53] zero
    logic [55:0] s_axis_tdata = '0;
    // [3:0] op
    logic [3:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // [7:0] status_word, [15:8] status_word_two
    logic [15:0] m_axis_tdata;

    psw_flag_update_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 clk = ~clk;

    // ALU items still waiting to be offered, and the item now on the bus.
    item_t alu_ops_to_send[$];
    item_t item_on_bus;

    // Status words the unit should return, oldest first.
    psw_t  psw_due[$];

    // Our own copy of the two status words, updated as items are accepted.
    logic [7:0] word_one = '0;
    logic [7:0] word_two = '0;

    int  n_items;
    int  items_in = 0;
    int  results_out = 0;
    int  error_count = 0;
    bit  item_taken = 1'b0;
    int  quiet_cycles = 0;

    task automatic report_failure(input string msg);
        $display("ERROR at %0t: %s", $realtime, msg);
        error_count++;
    endtask

    // Applies the flag rule of one item to our copy of the words and returns
    // both words as the unit should report them.
    function automatic psw_t update_flags(input item_t it);
        logic [16:0] r;
        logic [15:0] a;
        logic [15:0] b;
        logic [4:0]  nibble_sum;
        psw_t        words;
        r = it.raw_result;
        a = it.operand_a;
        b = it.operand_b;
        nibble_sum = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'b0, it.carry_in};
        case (it.op)
            OP_ADD8, OP_SUB8:
            begin
                word_one[BIT_CY] = r[8];
                if (it.op == OP_ADD8)
                begin
                    word_one[BIT_AC] = nibble_sum[4];
                    word_one[BIT_OV] = ~(a[7] ^ b[7]) & (a[7] ^ r[7]);
                end
                else
                begin
                    // Borrow out of the low nibble, borrow in included.
                    word_one[BIT_AC] = ({1'b0, a[3:0]} < ({1'b0, b[3:0]} + {4'b0, it.carry_in}));
                    word_one[BIT_OV] = (a[7] ^ b[7]) & (a[7] ^ r[7]);
                end
                word_two[BIT_N] = r[7];
                word_two[BIT_Z] = (r[7:0] == 8'h00);
                if (it.update_parity)
                    word_one[BIT_P] = ^r[7:0];
            end
            OP_LOGIC8:
            begin
                word_two[BIT_N] = r[7];
                word_two[BIT_Z] = (r[7:0] == 8'h00);
            end
            OP_SHIFT8:
            begin
                word_one[BIT_CY] = it.shift_carry;
                word_two[BIT_N] = r[7];
                word_two[BIT_Z] = (r[7:0] == 8'h00);
            end
            OP_SHIFT16:
            begin
                word_one[BIT_CY] = it.shift_carry;
                word_two[BIT_N] = r[15];
                word_two[BIT_Z] = (r[15:0] == 16'h0000);
            end
            OP_MULDIV8:
            begin
                word_one[BIT_CY] = 1'b0;
                word_one[BIT_OV] = it.overflow_in;
            end
            OP_ADD16, OP_SUB16:
            begin
                word_one[BIT_CY] = r[16];
                if (it.op == OP_ADD16)
                    word_one[BIT_OV] = ~(a[15] ^ b[15]) & (a[15] ^ r[15]);
                else
                    word_one[BIT_OV] = (a[15] ^ b[15]) & (a[15] ^ r[15]);
                word_two[BIT_N] = r[15];
                word_two[BIT_Z] = (r[15:0] == 16'h0000);
            end
            OP_LOGIC16:
            begin
                word_two[BIT_N] = r[15];
                word_two[BIT_Z] = (r[15:0] == 16'h0000);
            end
            OP_PARITY:
                word_one[BIT_P] = ^r[7:0];
            OP_LOAD:
            begin
                word_one = a[7:0];
                word_two = b[7:0];
            end
            default:
                ;
        endcase
        words.one = word_one;
        words.two = word_two;
        return words;
    endfunction

    function automatic item_t alu_item(input op_t op, input logic [16:0] r,
                                       input logic [15:0] a, input logic [15:0] b,
                                       input bit cin, input bit upd, input bit sc,
                                       input bit ovi);
        item_t it;
        it.op            = op;
        it.raw_result    = r;
        it.operand_a     = a;
        it.operand_b     = b;
        it.carry_in      = cin;
        it.update_parity = upd;
        it.shift_carry   = sc;
        it.overflow_in   = ovi;
        return it;
    endfunction

    // Random item whose raw result mostly matches what an ALU would produce
    // from the operands, so that carries, borrows and overflows come out
    // consistent; some results are plain noise.
    function automatic item_t random_alu_item();
        item_t       it;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 4)
            it.op = op_t'(4'($urandom_range(OP_FIRST_UNUSED, OP_LAST_UNUSED)));
        else if (pick < 9)
            it.op = OP_LOAD;
        else
            it.op = op_t'(4'($urandom_range(OP_ADD8, OP_PARITY)));
        it.operand_a     = 16'($urandom);
        it.operand_b     = 16'($urandom);
        it.carry_in      = 1'($urandom);
        it.update_parity = 1'($urandom);
        it.shift_carry   = 1'($urandom);
        it.overflow_in   = 1'($urandom);
        // Small operands now and then, so that narrow sums and zeros turn up.
        if ($urandom_range(0, 3) == 0)
            it.operand_a[15:4] = '0;
        if ($urandom_range(0, 3) == 0)
            it.operand_b[15:4] = '0;
        case (it.op)
            OP_ADD8:
                it.raw_result = 17'(it.operand_a[7:0]) + 17'(it.operand_b[7:0])
                              + 17'(it.carry_in);
            OP_SUB8:
                it.raw_result = (17'(it.operand_a[7:0]) - 17'(it.operand_b[7:0])
                              - 17'(it.carry_in)) & 17'h001FF;
            OP_ADD16:
                it.raw_result = 17'(it.operand_a) + 17'(it.operand_b) + 17'(it.carry_in);
            OP_SUB16:
                it.raw_result = 17'(it.operand_a) - 17'(it.operand_b) - 17'(it.carry_in);
            OP_LOGIC8, OP_LOGIC16:
            begin
                case ($urandom_range(0, 2))
                    0: it.raw_result = 17'(it.operand_a & it.operand_b);
                    1: it.raw_result = 17'(it.operand_a | it.operand_b);
                    default: it.raw_result = 17'(it.operand_a ^ it.operand_b);
                endcase
            end
            default:
                it.raw_result = 17'($urandom);
        endcase
        if ($urandom_range(0, 4) == 0)
            it.raw_result = 17'($urandom);
        // Force a zero result now and then to reach the zero flag.
        if ($urandom_range(0, 15) == 0)
        begin
            if (it.op inside {OP_SHIFT16, OP_ADD16, OP_SUB16, OP_LOGIC16})
                it.raw_result[15:0] = '0;
            else
                it.raw_result[7:0] = '0;
        end
        return it;
    endfunction

    // Sender: offers the next item at the falling edge, holding it until it
    // is taken, with random gaps between items.
    int send_gap = 0;

    always @(negedge clk)
    begin
        if (rst_n && (!s_axis_tvalid || item_taken))
        begin
            // No gaps near the long hold-off, so that the unit fills up,
            // and none in the closing stretch.
            if (send_gap == 0 && items_in + QUIET_TAIL < n_items
                && !(items_in >= HOLD_AT - 4 && items_in < HOLD_AT + 4)
                && $urandom_range(0, 7) == 0)
                send_gap = $urandom_range(1, 9);
            if (send_gap > 0 || alu_ops_to_send.size() == 0)
            begin
                if (send_gap > 0)
                    send_gap--;
                s_axis_tvalid <= 1'b0;
            end
            else
            begin
                item_on_bus = alu_ops_to_send.pop_front();
                s_axis_tdata <= {3'b000, item_on_bus.overflow_in, item_on_bus.shift_carry,
                                 item_on_bus.update_parity, item_on_bus.carry_in,
                                 item_on_bus.operand_b, item_on_bus.operand_a,
                                 item_on_bus.raw_result};
                s_axis_tuser  <= item_on_bus.op;
                s_axis_tvalid <= 1'b1;
            end
        end
    end

    // Receiver: random stall bursts, plus one long hold-off so the input
    // side has to back up.
    int  recv_gap = 0;
    int  hold_left = 0;
    bit  hold_done = 1'b0;

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!hold_done && items_in >= HOLD_AT)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else if (recv_gap > 0)
            begin
                recv_gap--;
                m_axis_tready <= 1'b0;
            end
            else if (items_in + QUIET_TAIL < n_items && $urandom_range(0, 7) == 0)
            begin
                recv_gap = $urandom_range(1, 9) - 1;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // Input side: each accepted item updates our words and queues the
    // status words it should produce.
    always @(posedge clk)
    begin
        item_taken = rst_n && s_axis_tvalid && s_axis_tready;
        if (item_taken)
        begin
            psw_due.push_back(update_flags(item_on_bus));
            items_in++;
        end
    end

    // Output side: compare each returned item with the oldest expectation.
    always @(posedge clk)
    begin
        psw_t got;
        psw_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = psw_t'(m_axis_tdata);
            results_out++;
            if (psw_due.size() == 0)
                report_failure($sformatf("result %0d arrived with none expected (%h)",
                                         results_out, m_axis_tdata));
            else
            begin
                want = psw_due.pop_front();
                if (got.one !== want.one)
                    report_failure($sformatf("result %0d status_word: got %h, want %h",
                                             results_out, got.one, want.one));
                if (got.two !== want.two)
                    report_failure($sformatf("result %0d status_word_two: got %h, want %h",
                                             results_out, got.two, want.two));
            end
        end
    end

    // Watchdog: ends the run if nothing moves on either side for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("Timeout: no item moved for %0d cycles", STALL_LIMIT);
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    initial
    begin
        // Directed items: flag extremes and every op, including the
        // undecoded codes and inputs that the op ignores.
        alu_ops_to_send.push_back(alu_item(OP_LOAD,    17'h00000, 16'hFFFF, 16'hFFFF, 0, 0, 0, 0));
        alu_ops_to_send.push_back(alu_item(OP_ADD8,    17'h00100, 16'h0080, 16'h0080, 0, 1, 0, 0));
        alu_ops_to_send.push_back(alu_item(OP_ADD8,    17'h00080, 16'h007F, 16'h0001, 0, 0, 0, 0));
        alu_ops_to_send.push_back(alu_item(OP_ADD8,    17'h00010, 16'h000F, 16'h0000, 1, 1, 1, 1));
        alu_ops_to_send.push_back(alu_item(OP_SUB8,    17'h001FF, 16'h0000, 16'h0001, 0, 1, 0, 0));
        alu_ops_to_send.push_back(alu_item(OP_SUB8,    17'h0007E, 16'h0080, 16'h0001, 1, 0, 0, 0));
        alu_ops_to_send.push_back(alu_item(OP_SUB8,    17'h00000, 16'h0005, 16'h0005, 0, 1, 0, 0));
        alu_ops_to_send.push_back(alu_item(OP_LOGIC8,  17'h1FFFF, 16'hFFFF, 16'hFFFF, 1, 1, 1, 1));
        alu_ops_to_send.push_back(alu_item(OP_LOGIC8,  17'h00000, 16'h0000, 16'h0000, 0, 0, 0, 0));
        alu_ops_to_send.push_back(alu_item(OP_SHIFT8,  17'h00080, 16'h0040, 16'h0000, 0, 0, 1, 0));
        alu_ops_to_send.push_back(alu_item(OP_SHIFT8,  17'h00000, 16'h0001, 16'h0000, 1, 0, 0, 1));
        alu_ops_to_send.push_back(alu_item(OP_SHIFT16, 17'h08000, 16'h4000, 16'h0000, 0, 0, 1, 0));
        alu_ops_to_send.push_back(alu_item(OP_SHIFT16, 17'h10000, 16'h8000, 16'h0000, 0, 0, 0, 0));
        alu_ops_to_send.push_back(alu_item(OP_MULDIV8, 17'h1FFFF, 16'h00FF, 16'h00FF, 1, 1, 1, 1));
        alu_ops_to_send.push_back(alu_item(OP_MULDIV8, 17'h00000, 16'h0000, 16'h0000, 0, 0, 0, 0));
        alu_ops_to_send.push_back(alu_item(OP_ADD16,   17'h08000, 16'h7FFF, 16'h0001, 0, 0, 0, 0));
        alu_ops_to_send.push_back(alu_item(OP_ADD16,   17'h1FFFF, 16'hFFFF, 16'hFFFF, 1, 0, 0, 0));
        alu_ops_to_send.push_back(alu_item(OP_SUB16,   17'h1FFFF, 16'h0000, 16'h0001, 0, 0, 0, 0));
        alu_ops_to_send.push_back(alu_item(OP_SUB16,   17'h07FFF, 16'h8000, 16'h0001, 0, 0, 0, 0));
        alu_ops_to_send.push_back(alu_item(OP_LOGIC16, 17'h00000, 16'h00FF, 16'hFF00, 0, 0, 0, 0));
        alu_ops_to_send.push_back(alu_item(OP_LOGIC16, 17'h0FFFF, 16'hFFFF, 16'hFFFF, 0, 0, 0, 0));
        alu_ops_to_send.push_back(alu_item(OP_PARITY,  17'h00001, 16'h0000, 16'h0000, 0, 0, 0, 0));
        alu_ops_to_send.push_back(alu_item(OP_PARITY,  17'h1FEFF, 16'h0000, 16'h0000, 1, 1, 1, 1));
        alu_ops_to_send.push_back(alu_item(op_t'(OP_FIRST_UNUSED), 17'h1FFFF, 16'hFFFF,
                                           16'hFFFF, 1, 1, 1, 1));
        alu_ops_to_send.push_back(alu_item(op_t'(OP_LAST_UNUSED), 17'h00000, 16'h0000,
                                           16'h0000, 0, 0, 0, 0));
        for (int i = 0; i < RANDOM_ITEMS; i++)
            alu_ops_to_send.push_back(random_alu_item());
        n_items = alu_ops_to_send.size();

        // Reset is released at a falling edge, where the inputs change too.
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Wait until every item is in and every expected result is out.
        do
            @(negedge clk);
        while (items_in < n_items || psw_due.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

`default_nettype wire
